FILE: rtl/svv_pkg.sv
// Shared types, constants and the character classifier for the semantic
// version validator. No dependencies.
package svv_pkg;

  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned COMP_W   = 3;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W    = $clog2(FIFO_DEPTH + 1);

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

  localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = 16'd64;
  localparam logic [COMP_W-1:0] CORE_PARTS       = 3'd3;
  localparam logic [COMP_W-1:0] CORE_PARTS_SAT   = 3'd7;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_HYPHEN,
    CLS_PLUS,
    CLS_DOT,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    cls_e cls;
    logic has_char;
    logic last;
  } item_t;

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    r = CLS_OTHER;
    if (c == 8'h30) begin
      r = CLS_ZERO;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      r = CLS_DIGIT;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      r = CLS_ALPHA;
    end else if (c == 8'h2D) begin
      r = CLS_HYPHEN;
    end else if (c == 8'h2B) begin
      r = CLS_PLUS;
    end else if (c == 8'h2E) begin
      r = CLS_DOT;
    end
    return r;
  endfunction

endpackage

FILE: rtl/svv_front.sv
// Front end: accepts characters and registers them with their class.
// Depends on svv_pkg.
module svv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        character_i,
  input  logic              has_char_i,
  input  logic              last_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output svv_pkg::item_t    q_data_o
);

  logic           valid_q, valid_d;
  svv_pkg::item_t item_q;
  logic           accept;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_data_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cls      <= svv_pkg::classify(character_i);
      item_q.has_char <= has_char_i;
      item_q.last     <= last_i;
    end
  end

endmodule

FILE: rtl/svv_fifo.sv
// Short queue of classified transactions between front and back.
// Depends on svv_pkg.
module svv_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  svv_pkg::item_t    data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output svv_pkg::item_t    data_o
);

  svv_pkg::item_t                   mem_q [svv_pkg::FIFO_DEPTH];
  logic [svv_pkg::PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [svv_pkg::CNT_W-1:0]        count_q, count_d;

  assign full_o  = (count_q == svv_pkg::CNT_W'(svv_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == svv_pkg::PTR_W'(svv_pkg::FIFO_DEPTH - 1)) ? '0
                                                                            : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == svv_pkg::PTR_W'(svv_pkg::FIFO_DEPTH - 1)) ? '0
                                                                            : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/svv_back.sv
// Back end: string state machine over classified characters, verdict
// register on the output channel. Depends on svv_pkg.
module svv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  svv_pkg::item_t              item_i,
  output logic                        item_pop_o,
  input  logic [svv_pkg::LEN_W-1:0]   max_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        valid_res_o
);

  typedef enum logic [1:0] {
    SEC_CORE,
    SEC_PRE,
    SEC_BUILD
  } sec_e;

  sec_e                        sec_q, sec_d;
  logic [svv_pkg::COMP_W-1:0]  comp_q, comp_d, comp_end;
  logic [1:0]                  len_q, len_d;
  logic                        sz_q, sz_d;
  logic                        ad_q, ad_d;
  logic                        fail_q, fail_d;
  logic [svv_pkg::LEN_W-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        res_q, res_d;
  logic                        out_free;
  logic                        is_digit, is_ident;

  function automatic logic piece_ok(input sec_e s, input logic [1:0] len,
                                    input logic sz, input logic ad);
    logic ok;
    ok = 1'b1;
    if (len == 2'd0) begin
      ok = 1'b0;
    end else if (s != SEC_BUILD && ad && len == 2'd2 && sz) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [svv_pkg::COMP_W-1:0] comp_inc(
      input logic [svv_pkg::COMP_W-1:0] v);
    return (v == svv_pkg::CORE_PARTS_SAT) ? v : v + 1'b1;
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign item_pop_o  = item_valid_i && (!item_i.last || out_free);
  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

  assign is_digit = item_i.cls inside {svv_pkg::CLS_ZERO, svv_pkg::CLS_DIGIT};
  assign is_ident = is_digit ||
                    (item_i.cls inside {svv_pkg::CLS_ALPHA, svv_pkg::CLS_HYPHEN});

  always_comb begin
    sec_d       = sec_q;
    comp_d      = comp_q;
    len_d       = len_q;
    sz_d        = sz_q;
    ad_d        = ad_q;
    fail_d      = fail_q;
    cnt_d       = cnt_q;
    comp_end    = comp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (item_pop_o) begin
      if (item_i.has_char) begin
        if (cnt_q == '1) begin
          fail_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
        if (cnt_d > max_length_i) begin
          fail_d = 1'b1;
        end

        case (sec_q)
          SEC_CORE: begin
            if (is_digit) begin
              if (len_q == 2'd0) sz_d = (item_i.cls == svv_pkg::CLS_ZERO);
              if (len_q != 2'd2) len_d = len_q + 1'b1;
            end else if (item_i.cls == svv_pkg::CLS_DOT) begin
              if (!piece_ok(sec_q, len_q, sz_q, ad_q)) fail_d = 1'b1;
              comp_d = comp_inc(comp_q);
              if (comp_d >= svv_pkg::CORE_PARTS) fail_d = 1'b1;
              len_d = 2'd0;
              sz_d  = 1'b0;
              ad_d  = 1'b1;
            end else if (item_i.cls inside {svv_pkg::CLS_HYPHEN, svv_pkg::CLS_PLUS}) begin
              if (!piece_ok(sec_q, len_q, sz_q, ad_q)) fail_d = 1'b1;
              comp_d = comp_inc(comp_q);
              if (comp_d != svv_pkg::CORE_PARTS) fail_d = 1'b1;
              sec_d = (item_i.cls == svv_pkg::CLS_HYPHEN) ? SEC_PRE : SEC_BUILD;
              len_d = 2'd0;
              sz_d  = 1'b0;
              ad_d  = 1'b1;
            end else begin
              fail_d = 1'b1;
            end
          end
          SEC_PRE, SEC_BUILD: begin
            if (item_i.cls == svv_pkg::CLS_DOT) begin
              if (!piece_ok(sec_q, len_q, sz_q, ad_q)) fail_d = 1'b1;
              len_d = 2'd0;
              sz_d  = 1'b0;
              ad_d  = 1'b1;
            end else if (item_i.cls == svv_pkg::CLS_PLUS) begin
              if (sec_q == SEC_BUILD) begin
                fail_d = 1'b1;
              end else begin
                if (!piece_ok(sec_q, len_q, sz_q, ad_q)) fail_d = 1'b1;
                sec_d = SEC_BUILD;
                len_d = 2'd0;
                sz_d  = 1'b0;
                ad_d  = 1'b1;
              end
            end else if (is_ident) begin
              if (len_q == 2'd0) sz_d = (item_i.cls == svv_pkg::CLS_ZERO);
              if (!is_digit) ad_d = 1'b0;
              if (len_q != 2'd2) len_d = len_q + 1'b1;
            end else begin
              fail_d = 1'b1;
            end
          end
          default: begin
            fail_d = 1'b1;
          end
        endcase
      end

      if (item_i.last) begin
        if (cnt_d == '0) fail_d = 1'b1;
        if (sec_d == SEC_CORE) begin
          if (!piece_ok(sec_d, len_d, sz_d, ad_d)) fail_d = 1'b1;
          comp_end = comp_inc(comp_d);
          if (comp_end != svv_pkg::CORE_PARTS) fail_d = 1'b1;
        end else if (!piece_ok(sec_d, len_d, sz_d, ad_d)) begin
          fail_d = 1'b1;
        end
        res_d       = !fail_d;
        out_valid_d = 1'b1;
        // string done: back to the start of a new one
        sec_d  = SEC_CORE;
        comp_d = '0;
        len_d  = 2'd0;
        sz_d   = 1'b0;
        ad_d   = 1'b1;
        fail_d = 1'b0;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q       <= SEC_CORE;
      comp_q      <= '0;
      len_q       <= 2'd0;
      sz_q        <= 1'b0;
      ad_q        <= 1'b1;
      fail_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sec_q       <= sec_d;
      comp_q      <= comp_d;
      len_q       <= len_d;
      sz_q        <= sz_d;
      ad_q        <= ad_d;
      fail_q      <= fail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(item_pop_o && item_i.last))
    else $error("result without an end-of-string transaction");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop_o && item_i.last) |=> (cnt_q == '0 && sec_q == SEC_CORE && !fail_q))
    else $error("string state not cleared after verdict");

  a_suffix_needs_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_q != SEC_CORE && !fail_q) |-> (comp_q == svv_pkg::CORE_PARTS))
    else $error("suffix section entered with incomplete core");

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != 2'd3)
    else $error("identifier length went past saturation");
`endif

endmodule

FILE: rtl/semantic_version_validator_unit.sv
// The verdict passes through the front register, the FIFO and the verdict register
// after the end-of-string transaction is accepted. Throughput: one character per cycle
// sustained while the verdict output is not stalled, held by the back end's state update.
// Reset: asynchronous, active low; string state cleared, max_length = 64,
// no clearing pass. Top level; depends on svv_pkg, svv_front, svv_fifo, svv_back.
module semantic_version_validator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    character_i,
  input  logic                          has_char_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          valid_res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svv_pkg::ADDR_W-1:0]    paddr,
  input  logic [svv_pkg::DATA_W-1:0]    pwdata,
  output logic [svv_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [svv_pkg::LEN_W-1:0] max_length_q;
  logic                      cfg_wr;
  logic                      q_full, q_push, q_valid, q_pop;
  svv_pkg::item_t            q_in, q_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == svv_pkg::REG_MAX_LENGTH);
  assign prdata = (paddr[2:2] == svv_pkg::REG_MAX_LENGTH)
                ? {{(svv_pkg::DATA_W - svv_pkg::LEN_W){1'b0}}, max_length_q}
                : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= svv_pkg::MAX_LENGTH_RESET;
    end else if (cfg_wr) begin
      max_length_q <= pwdata[svv_pkg::LEN_W-1:0];
    end
  end

  svv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  svv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  svv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .max_length_i (max_length_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .valid_res_o  (valid_res_o)
  );

endmodule

FILE: bench/svv_checker.sv
`timescale 1ns / 100ps
// Verdict checker for semantic_version_validator_unit: snoops the APB port and
// both streaming channels, predicts each verdict and compares. Depends on svv_pkg.
module svv_checker
  import svv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        character_i,
  input  logic              has_char_i,
  input  logic              last_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              valid_res_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  input  logic              pready_i,
  output int                errors_o,
  output int                pending_o,
  output int                verdicts_o,
  output int                passes_o
);

  typedef enum logic [1:0] {
    PART_CORE,
    PART_PRE,
    PART_BUILD
  } part_e;

  localparam logic [7:0]       CH_ZERO   = 8'h30;
  localparam logic [7:0]       CH_NINE   = 8'h39;
  localparam logic [7:0]       CH_UPPER_A = 8'h41;
  localparam logic [7:0]       CH_UPPER_Z = 8'h5A;
  localparam logic [7:0]       CH_LOWER_A = 8'h61;
  localparam logic [7:0]       CH_LOWER_Z = 8'h7A;
  localparam logic [7:0]       CH_DASH   = 8'h2D;
  localparam logic [7:0]       CH_PLUS   = 8'h2B;
  localparam logic [7:0]       CH_DOT    = 8'h2E;
  localparam logic [LEN_W-1:0] COUNT_MAX = 16'hFFFF;

  logic [LEN_W-1:0]  len_limit;
  logic [LEN_W-1:0]  byte_count;
  part_e             part;
  logic [COMP_W-1:0] core_done;
  logic [1:0]        piece_len;
  bit                lead_zero;
  bit                only_digits;
  bit                bad;
  bit                verdict_q[$];
  int                errors;
  int                verdicts;
  int                passes;

  function automatic bit is_num(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_ident(input logic [7:0] c);
    return is_num(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_DASH;
  endfunction

  // Judges the piece that just closed; the zero rule holds outside the build part.
  function automatic bit piece_good();
    if (piece_len == 2'd0) return 1'b0;
    if (part == PART_BUILD) return 1'b1;
    return !(only_digits && piece_len >= 2'd2 && lead_zero);
  endfunction

  task automatic fresh_piece();
    piece_len   = 2'd0;
    lead_zero   = 1'b0;
    only_digits = 1'b1;
  endtask

  task automatic clear_string();
    part       = PART_CORE;
    core_done  = '0;
    bad        = 1'b0;
    byte_count = '0;
    fresh_piece();
  endtask

  task automatic grow_piece(input logic [7:0] c);
    if (piece_len == 2'd0) lead_zero = (c == CH_ZERO);
    if (!is_num(c)) only_digits = 1'b0;
    if (piece_len < 2'd2) piece_len = piece_len + 2'd1;
  endtask

  task automatic end_core_piece();
    if (!piece_good()) bad = 1'b1;
    if (core_done < CORE_PARTS_SAT) core_done = core_done + 1'b1;
  endtask

  task automatic scan_byte(input logic [7:0] c);
    if (part == PART_CORE) begin
      if (is_num(c)) begin
        grow_piece(c);
      end else if (c == CH_DOT) begin
        end_core_piece();
        if (core_done >= CORE_PARTS) bad = 1'b1;
        fresh_piece();
      end else if (c == CH_DASH || c == CH_PLUS) begin
        end_core_piece();
        if (core_done != CORE_PARTS) bad = 1'b1;
        part = (c == CH_DASH) ? PART_PRE : PART_BUILD;
        fresh_piece();
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (c == CH_DOT) begin
        if (!piece_good()) bad = 1'b1;
        fresh_piece();
      end else if (c == CH_PLUS) begin
        if (part == PART_BUILD) begin
          bad = 1'b1;
        end else begin
          if (!piece_good()) bad = 1'b1;
          part = PART_BUILD;
          fresh_piece();
        end
      end else if (is_ident(c)) begin
        grow_piece(c);
      end else begin
        bad = 1'b1;
      end
    end
  endtask

  task automatic take_item(input logic [7:0] c, input logic hc, input logic lst);
    if (hc) begin
      if (byte_count == COUNT_MAX) bad = 1'b1;
      else byte_count = byte_count + 1'b1;
      if (byte_count > len_limit) bad = 1'b1;
      scan_byte(c);
    end
    if (lst) begin
      if (byte_count == '0) bad = 1'b1;
      if (part == PART_CORE) begin
        end_core_piece();
        if (core_done != CORE_PARTS) bad = 1'b1;
      end else if (!piece_good()) begin
        bad = 1'b1;
      end
      verdict_q.push_back(!bad);
      clear_string();
    end
  endtask

  task automatic note_mismatch(input string what, input logic exp, input logic got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected valid_res %b, got %b", $time, what, exp, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit exp;
    if (!rst_ni) begin
      len_limit = MAX_LENGTH_RESET;
      clear_string();
      verdict_q.delete();
      errors   = 0;
      verdicts = 0;
      passes   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == REG_MAX_LENGTH)
        len_limit = pwdata_i[LEN_W-1:0];
      if (in_valid_i && !in_stall_i)
        take_item(character_i, has_char_i, last_i);
      if (out_valid_i && !out_stall_i) begin
        verdicts++;
        if (valid_res_i === 1'b1) passes++;
        if (verdict_q.size() == 0) begin
          note_mismatch("verdict with no string pending", 1'bx, valid_res_i);
        end else begin
          exp = verdict_q.pop_front();
          if (valid_res_i !== exp) note_mismatch("verdict mismatch", exp, valid_res_i);
        end
      end
    end
    errors_o   <= errors;
    pending_o  <= verdict_q.size();
    verdicts_o <= verdicts;
    passes_o   <= passes;
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the semantic_version_validator_unit bench: clock, reset, APB setup,
// string stimulus and output back-pressure. Depends on svv_pkg, svv_checker and the unit.
module tb;
  import svv_pkg::*;

  typedef enum int {
    MUT_REPLACE,
    MUT_PLUS,
    MUT_DOT,
    MUT_DROP
  } mutation_e;

  localparam logic [7:0]        CH_NUL     = 8'h00;
  localparam logic [7:0]        CH_ZERO    = 8'h30;
  localparam logic [7:0]        CH_UPPER_A = 8'h41;
  localparam logic [7:0]        CH_LOWER_A = 8'h61;
  localparam logic [7:0]        CH_LOWER_X = 8'h78;
  localparam logic [7:0]        CH_DASH    = 8'h2D;
  localparam logic [7:0]        CH_PLUS    = 8'h2B;
  localparam logic [7:0]        CH_DOT     = 8'h2E;
  localparam logic [ADDR_W-1:0] ADDR_MAX_LENGTH = {REG_MAX_LENGTH, 2'b00};
  localparam int                HOLD_CYCLES = 300;
  localparam int                PHASE_ITEMS = 200;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        chr;
  logic              has_char;
  logic              is_last;
  logic              out_valid;
  logic              out_stall;
  logic              valid_res;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   errors;
  int   pending;
  int   verdicts;
  int   passes;
  int   items_sent;
  int   bytes_sent;
  int   limits_used;
  int   hold_req;
  int   hold_served;
  bit   gaps_on;
  logic [7:0] text_q[$];

  semantic_version_validator_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .character_i(chr),
    .has_char_i (has_char),
    .last_i     (is_last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .valid_res_o(valid_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  svv_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .character_i(chr),
    .has_char_i (has_char),
    .last_i     (is_last),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .valid_res_i(valid_res),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .errors_o   (errors),
    .pending_o  (pending),
    .verdicts_o (verdicts),
    .passes_o   (passes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL semantic_version_validator_unit");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // One transaction on the input channel; valid stays high into the next call.
  task automatic put_item(input logic [7:0] c, input logic hc, input logic lst);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    chr      <= c;
    has_char <= hc;
    is_last  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (hc || lst) items_sent++;
    if (hc) bytes_sent++;
  endtask

  task automatic send_text(input bit bare_end);
    logic [7:0] noise;
    for (int i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 99) < 8) begin
        noise = 8'($urandom_range(0, 255));
        put_item(noise, 1'b0, 1'b0);
      end
      put_item(text_q[i], 1'b1, !bare_end && i == text_q.size() - 1);
    end
    if (bare_end || text_q.size() == 0) begin
      noise = 8'($urandom_range(0, 255));
      put_item(noise, 1'b0, 1'b1);
    end
  endtask

  task automatic load_text(input string str);
    text_q.delete();
    for (int i = 0; i < str.len(); i++) text_q.push_back(str[i]);
  endtask

  task automatic send_version(input string str);
    load_text(str);
    send_text(1'b0);
  endtask

  task automatic pad_text(input int n);
    repeat (n) text_q.push_back(CH_LOWER_X);
  endtask

  // Waits until every verdict is in, plus the pipeline depth for trailing bytes.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limit(input logic [LEN_W-1:0] limit);
    logic [DATA_W-1:0] word;
    word = $urandom;
    word[LEN_W-1:0] = limit;
    cfg_write(ADDR_MAX_LENGTH, word);
    limits_used++;
  endtask

  task automatic push_number();
    int r;
    logic [7:0] d;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      text_q.push_back(CH_ZERO);
    end else if (r == 3) begin
      // leading zero
      text_q.push_back(CH_ZERO);
      repeat ($urandom_range(1, 2)) begin
        d = CH_ZERO + 8'($urandom_range(0, 9));
        text_q.push_back(d);
      end
    end else begin
      d = CH_ZERO + 8'($urandom_range(1, 9));
      text_q.push_back(d);
      repeat ($urandom_range(0, 3)) begin
        d = CH_ZERO + 8'($urandom_range(0, 9));
        text_q.push_back(d);
      end
    end
  endtask

  task automatic push_ident();
    int r;
    int k;
    logic [7:0] d;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      // empty identifier
    end else if (r < 8) begin
      push_number();
    end else begin
      repeat ($urandom_range(1, 6)) begin
        k = $urandom_range(0, 63);
        if (k < 10) d = CH_ZERO + 8'(k);
        else if (k < 36) d = CH_UPPER_A + 8'(k - 10);
        else if (k < 62) d = CH_LOWER_A + 8'(k - 36);
        else d = CH_DASH;
        text_q.push_back(d);
      end
    end
  endtask

  // Mostly well-formed versions with random content; some mutated, some noise.
  task automatic random_phase(input int quota, input bit with_hold);
    int start;
    int strings;
    int kind;
    int parts;
    int pos;
    logic [7:0] d;
    mutation_e mut;
    start   = items_sent;
    strings = 0;
    while (items_sent - start < quota) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (with_hold && strings == 20) hold_req++;
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(0, 10)) begin
          if ($urandom_range(0, 3) == 0) d = 8'($urandom_range(0, 255));
          else d = 8'($urandom_range(CH_PLUS, 8'h7A));
          text_q.push_back(d);
        end
      end else begin
        parts = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 4) : 3;
        for (int k = 0; k < parts; k++) begin
          if (k > 0) text_q.push_back(CH_DOT);
          push_number();
        end
        if ($urandom_range(0, 99) < 45) begin
          text_q.push_back(CH_DASH);
          for (int k = $urandom_range(1, 3); k > 0; k--) begin
            push_ident();
            if (k > 1) text_q.push_back(CH_DOT);
          end
        end
        if ($urandom_range(0, 99) < 35) begin
          text_q.push_back(CH_PLUS);
          for (int k = $urandom_range(1, 3); k > 0; k--) begin
            push_ident();
            if (k > 1) text_q.push_back(CH_DOT);
          end
        end
        if (kind < 25 && text_q.size() > 0) begin
          pos = $urandom_range(0, text_q.size() - 1);
          mut = mutation_e'($urandom_range(0, 3));
          case (mut)
            MUT_REPLACE: begin
              d = 8'($urandom_range(0, 255));
              text_q[pos] = d;
            end
            MUT_PLUS: text_q.insert(pos, CH_PLUS);
            MUT_DOT:  text_q.insert(pos, CH_DOT);
            MUT_DROP: text_q.delete(pos);
            default: ;
          endcase
        end
      end
      send_text($urandom_range(0, 9) == 0);
      strings++;
    end
  endtask

  // Output back-pressure: short and long stalls, free stretches, and long holds.
  initial begin
    int stall_len;
    int free_len;
    int r;
    out_stall   <= 1'b0;
    hold_served = 0;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        stall_len   = HOLD_CYCLES;
        free_len    = $urandom_range(1, 8);
      end else if (r < 30) begin
        stall_len = 0;
        free_len  = $urandom_range(10, 60);
      end else begin
        stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        free_len  = $urandom_range(1, 8);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
    end
  end

  initial begin
    logic [7:0] d;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    chr         <= '0;
    has_char    <= 1'b0;
    is_last     <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    items_sent  = 0;
    bytes_sent  = 0;
    limits_used = 1;
    hold_req    = 0;
    gaps_on     = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed strings under the reset length limit of 64
    send_version("1.2.3");
    send_version("0.0.0");
    send_version("10.20.30-rc.1+build.007");
    send_version("01.2.3");
    send_version("1.2.3-01");
    send_version("1.2.3-0a.-x");
    send_version("1.2.3+a+b");
    send_version("1.2.3.4");
    send_version("1.2.3-");
    send_version("1.2.3+");
    send_version("1.2");
    send_version("1..3");
    send_version("1.2.3-a..b");
    send_version("v1.2.3");
    send_version("1.2.3-x+y.01");
    d = 8'($urandom_range(0, 255));
    put_item(d, 1'b0, 1'b0);
    load_text("");
    send_text(1'b0);
    load_text("9.9.9");
    send_text(1'b1);
    load_text("1.2.3");
    text_q.insert(3, CH_NUL);
    send_text(1'b0);
    load_text("1.2.3-");
    text_q.push_back(8'hFF);
    send_text(1'b0);
    load_text("1.2.3+Z");
    text_q.push_back(8'h80);
    send_text(1'b0);
    load_text("1.2.3-");
    pad_text(58);
    send_text(1'b0);
    load_text("1.2.3-");
    pad_text(59);
    send_text(1'b0);

    settle();
    set_limit(16'd0);
    random_phase(PHASE_ITEMS / 3, 1'b0);
    settle();
    set_limit(16'd5);
    random_phase(PHASE_ITEMS, 1'b1);
    settle();
    set_limit(LEN_W'($urandom_range(8, 20)));
    random_phase(PHASE_ITEMS, 1'b0);
    settle();
    set_limit(16'd64);
    random_phase(PHASE_ITEMS * 2, 1'b1);
    settle();
    set_limit(16'hFFFF);
    random_phase(PHASE_ITEMS, 1'b0);
    settle();
    set_limit(LEN_W'($urandom_range(0, 65535)));
    random_phase(PHASE_ITEMS, 1'b0);
    settle();
    set_limit(LEN_W'($urandom_range(20, 48)));
    random_phase(PHASE_ITEMS, 1'b1);
    settle();
    set_limit(16'd1);
    random_phase(PHASE_ITEMS / 3, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d verdicts (%0d valid) over %0d bytes in %0d transactions,",
             verdicts, passes, bytes_sent, items_sent);
    $display("under %0d length limits including 0 and 65535, with long output holds.",
             limits_used);
    if (errors == 0 && pending == 0) begin
      $display("PASS semantic_version_validator_unit");
    end else begin
      $display("FAIL semantic_version_validator_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/svv_pkg.sv
rtl/svv_front.sv
rtl/svv_fifo.sv
rtl/svv_back.sv
rtl/semantic_version_validator_unit.sv
bench/svv_checker.sv
bench/tb.sv
